// ===== src/swcs_pkg.sv =====
// shared types and constants of the smith-waterman cell scorer
`timescale 1ns / 1ps

package swcs_pkg;

    localparam int SCORE_W = 15;
    localparam int INDEX_W = 14;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 15'h7FFF;

    // traceback direction codes
    localparam logic [1:0] DIR_CENTER     = 2'd0;
    localparam logic [1:0] DIR_NORTH      = 2'd1;
    localparam logic [1:0] DIR_NORTH_WEST = 2'd2;
    localparam logic [1:0] DIR_WEST       = 2'd3;

    // item kinds
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CELL = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_MATCH    = 2'd0;
    localparam logic [1:0] CFG_MISMATCH = 2'd1;
    localparam logic [1:0] CFG_GAP      = 2'd2;

    // reset values of the configuration registers
    localparam logic [6:0] MATCH_RESET    = 7'd2;
    localparam logic [7:0] MISMATCH_RESET = 8'hFF;
    localparam logic [7:0] GAP_RESET      = 8'hFF;

    typedef struct packed {
        logic load;
        logic cell_start;
        logic calc;
    } cmd_t;

endpackage

// ===== src/swcs_ctrl.sv =====
// controller state machine of the smith-waterman cell scorer
`timescale 1ns / 1ps

module swcs_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          func,
    output logic          busy,
    output logic          result_strobe,
    output swcs_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   strobe_reg;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.load       = accept && (func == swcs_pkg::FUNC_LOAD);
        cmd.cell_start = accept && (func == swcs_pkg::FUNC_CELL);
        cmd.calc       = (state_reg == ST_CALC);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.cell_start)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= cmd.calc;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = strobe_reg;

    // a cell beat always turns into exactly one result, through the score step and the strobe register
    a_cell_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cell_start |=> busy)
        else $error("cell beat did not start the score step");
    a_calc_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && result_strobe)
        else $error("score step did not finish with a result");
    a_no_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !busy ##1 !result_strobe)
        else $error("load beat produced a result");
    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result without a score step");

endmodule

// ===== src/swcs_datapath.sv =====
// datapath of the smith-waterman cell scorer: stores, score update and best tracking
`timescale 1ns / 1ps

module swcs_datapath #(
    parameter int SIDE_LENGTH = 128
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  swcs_pkg::cmd_t                cmd,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic [6:0]                    ref_position,
    input  logic [7:0]                    ref_char,
    input  logic [7:0]                    row_char,
    input  logic                          start_req,
    output logic [swcs_pkg::INDEX_W-1:0]  cell_index,
    output logic [swcs_pkg::SCORE_W-1:0]  cell_score,
    output logic [1:0]                    direction,
    output logic [swcs_pkg::SCORE_W-1:0]  best_score,
    output logic [swcs_pkg::INDEX_W-1:0]  best_index,
    output logic                          matrix_done
);

    localparam int COL_W = (SIDE_LENGTH > 2) ? $clog2(SIDE_LENGTH) : 1;
    localparam int TOTAL = SIDE_LENGTH * SIDE_LENGTH;
    localparam int CNT_W = $clog2(TOTAL);
    localparam int EXT_W = (CNT_W > swcs_pkg::INDEX_W) ? CNT_W : swcs_pkg::INDEX_W;
    localparam int PAW   = (COL_W > 7) ? COL_W : 7;
    localparam int SW    = swcs_pkg::SCORE_W;

    // configuration
    logic        [6:0] match_reg;
    logic signed [7:0] mismatch_reg;
    logic signed [7:0] gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg    <= swcs_pkg::MATCH_RESET;
            mismatch_reg <= swcs_pkg::MISMATCH_RESET;
            gap_reg      <= swcs_pkg::GAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swcs_pkg::CFG_MATCH:    match_reg    <= cfg_data[6:0];
                swcs_pkg::CFG_MISMATCH: mismatch_reg <= cfg_data;
                swcs_pkg::CFG_GAP:      gap_reg      <= cfg_data;
                default:                ;
            endcase
        end
    end

    // position in the matrix
    logic [COL_W-1:0] col_reg,  col_next;
    logic [CNT_W-1:0] idx_reg,  idx_next;
    logic             row0_reg, row0_next;
    logic             last_col;
    logic             last_cell;
    logic [COL_W-1:0] rd_col;

    assign last_col  = (col_reg == COL_W'(SIDE_LENGTH - 1));
    assign last_cell = (idx_reg == CNT_W'(TOTAL - 1));
    assign rd_col    = start_req ? '0 : col_reg;

    always_comb
    begin
        col_next  = col_reg;
        idx_next  = idx_reg;
        row0_next = row0_reg;
        if (cmd.cell_start && start_req)
        begin
            col_next  = '0;
            idx_next  = '0;
            row0_next = 1'b1;
        end
        else if (cmd.calc)
        begin
            col_next  = last_col ? '0 : col_reg + COL_W'(1);
            idx_next  = last_cell ? '0 : idx_reg + CNT_W'(1);
            row0_next = last_cell ? 1'b1 : (last_col ? 1'b0 : row0_reg);
        end
    end

    // stores, read at the cell beat; the reference store is written at a load and the row store at the score step
    logic [7:0]    ref_mem [SIDE_LENGTH];
    logic [SW-1:0] row_mem [SIDE_LENGTH];
    logic [7:0]    refc_q;
    logic [SW-1:0] north_q;
    logic [PAW-1:0] pos_ext;
    logic           pos_ok;

    assign pos_ext = PAW'(ref_position);
    assign pos_ok  = (32'(ref_position) < SIDE_LENGTH);

    always_ff @(posedge clk)
    begin
        if (cmd.load && pos_ok)
        begin
            ref_mem[pos_ext[COL_W-1:0]] <= ref_char;
        end
        if (cmd.cell_start)
        begin
            refc_q <= ref_mem[rd_col];
        end
    end

    logic [SW-1:0] score;

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            row_mem[col_reg] <= score;
        end
        if (cmd.cell_start)
        begin
            north_q <= row_mem[rd_col];
        end
    end

    logic [7:0] qchar_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cell_start)
        begin
            qchar_reg <= row_char;
        end
    end

    // score of the cell
    logic [SW-1:0]      west_reg;
    logic [SW-1:0]      nw_reg;
    logic [SW-1:0]      best_reg;
    logic [EXT_W-1:0]   best_idx_reg;
    logic signed [16:0] diag;
    logic signed [16:0] gap_ext;
    logic signed [16:0] cand_nw, cand_n, cand_w, val;
    logic        [1:0]  dir;

    always_comb
    begin
        gap_ext = $signed({{9{gap_reg[7]}}, gap_reg});
        if (refc_q == qchar_reg)
        begin
            diag = $signed({10'd0, match_reg});
        end
        else
        begin
            diag = $signed({{9{mismatch_reg[7]}}, mismatch_reg});
        end
        cand_nw = $signed({2'b00, nw_reg}) + diag;
        cand_n  = $signed({2'b00, north_q}) + gap_ext;
        cand_w  = $signed({2'b00, west_reg}) + gap_ext;
        val = '0;
        dir = swcs_pkg::DIR_CENTER;
        if (!row0_reg && (col_reg != '0))
        begin
            // strict compares keep ties on the earlier candidate
            if (cand_nw > val)
            begin
                val = cand_nw;
                dir = swcs_pkg::DIR_NORTH_WEST;
            end
            if (cand_n > val)
            begin
                val = cand_n;
                dir = swcs_pkg::DIR_NORTH;
            end
            if (cand_w > val)
            begin
                val = cand_w;
                dir = swcs_pkg::DIR_WEST;
            end
        end
        if (val > $signed({2'b00, swcs_pkg::SCORE_MAX}))
        begin
            score = swcs_pkg::SCORE_MAX;
        end
        else
        begin
            score = val[SW-1:0];
        end
    end

    // best score, cleared on the first cell of a matrix
    logic [SW-1:0]    best_base;
    logic [EXT_W-1:0] bidx_base;
    logic [SW-1:0]    best_next;
    logic [EXT_W-1:0] bidx_next;
    logic [EXT_W-1:0] idx_ext;

    assign idx_ext = EXT_W'(idx_reg);

    always_comb
    begin
        best_base = (idx_reg == '0) ? '0 : best_reg;
        bidx_base = (idx_reg == '0) ? '0 : best_idx_reg;
        if (score > best_base)
        begin
            best_next = score;
            bidx_next = idx_ext;
        end
        else
        begin
            best_next = best_base;
            bidx_next = bidx_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            idx_reg      <= '0;
            row0_reg     <= 1'b1;
            west_reg     <= '0;
            nw_reg       <= '0;
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            idx_reg  <= idx_next;
            row0_reg <= row0_next;
            if (cmd.calc)
            begin
                west_reg     <= score;
                nw_reg       <= north_q;
                best_reg     <= best_next;
                best_idx_reg <= bidx_next;
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            cell_index  <= idx_ext[swcs_pkg::INDEX_W-1:0];
            cell_score  <= score;
            direction   <= dir;
            best_score  <= best_next;
            best_index  <= bidx_next[swcs_pkg::INDEX_W-1:0];
            matrix_done <= last_cell;
        end
    end

    a_first_cell_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc && (idx_reg == '0) |=> (best_score == cell_score))
        else $error("best score not restarted on the first cell");
    a_done_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc && last_cell |=> (idx_reg == '0) && row0_reg && (col_reg == '0))
        else $error("position did not wrap after the last cell");
    a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc && row0_reg |=> (cell_score == '0) && (direction == swcs_pkg::DIR_CENTER))
        else $error("row zero cell scored nonzero");

endmodule

// ===== src/smith_waterman_cell_scorer.sv =====
// top level of the smith-waterman cell scorer with linear gap
`timescale 1ns / 1ps

// usage:
// - a beat is taken at a rising edge with start high and busy low; func picks
//   a load (ref_char stored at column ref_position) or a cell of the matrix
// - cells come in raster order, row_char is the query character of the row,
//   start_req on a cell restarts the matrix at index 0
// - a load gives no result and busy stays low; start may stay high
// - a cell has two steps: the beat edge reads the reference character and
//   the north score from the column stores, then the calc state does the
//   add-compare step and writes the row store; busy is high in that state
// - the result shows for one cycle on result_strobe, in the cycle in which
//   busy falls, and a new beat may be taken in that same cycle
// - there is no way to hold results off; capture on result_strobe
// - config writes (cfg_valid, cfg_ready always high) are taken at any time
//   and are meant for idle periods; index 3 is ignored
// - reset clears position, west, northwest and best score and loads the
//   default scores; the stores are not cleared and must be loaded first
module smith_waterman_cell_scorer #(
    parameter int SIDE_LENGTH = 128
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [6:0]                    ref_position,
    input  logic [7:0]                    ref_char,
    input  logic [7:0]                    row_char,
    input  logic                          start_req,
    output logic                          result_strobe,
    output logic [swcs_pkg::INDEX_W-1:0]  cell_index,
    output logic [swcs_pkg::SCORE_W-1:0]  cell_score,
    output logic [1:0]                    direction,
    output logic [swcs_pkg::SCORE_W-1:0]  best_score,
    output logic [swcs_pkg::INDEX_W-1:0]  best_index,
    output logic                          matrix_done,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [7:0]                    cfg_data
);

    swcs_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    swcs_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .func          (func),
        .busy          (busy),
        .result_strobe (result_strobe),
        .cmd           (cmd)
    );

    swcs_datapath #(
        .SIDE_LENGTH (SIDE_LENGTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ref_position (ref_position),
        .ref_char     (ref_char),
        .row_char     (row_char),
        .start_req    (start_req),
        .cell_index   (cell_index),
        .cell_score   (cell_score),
        .direction    (direction),
        .best_score   (best_score),
        .best_index   (best_index),
        .matrix_done  (matrix_done)
    );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the smith-waterman cell scorer
`timescale 1ns / 1ps

module testbench;

    import swcs_pkg::*;

    localparam int SIDE = 128;
    localparam int CELLS = SIDE * SIDE;
    localparam int SETTLE = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 95;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [SCORE_W-1:0] score;
        logic [1:0]         dir;
        logic [SCORE_W-1:0] best;
        logic [INDEX_W-1:0] best_idx;
        logic               done;
    } cell_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                func;
    logic [6:0]          ref_position;
    logic [7:0]          ref_char;
    logic [7:0]          row_char;
    logic                start_req;
    logic                result_strobe;
    logic [INDEX_W-1:0]  cell_index;
    logic [SCORE_W-1:0]  cell_score;
    logic [1:0]          direction;
    logic [SCORE_W-1:0]  best_score;
    logic [INDEX_W-1:0]  best_index;
    logic                matrix_done;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [7:0]          cfg_data;

    // alignment state as the block should hold it
    logic [7:0]          col_chars [SIDE];
    logic [SCORE_W-1:0]  row_above [SIDE];
    logic [SCORE_W-1:0]  west_q;
    logic [SCORE_W-1:0]  diag_q;
    int                  cell_pos;
    logic [SCORE_W-1:0]  top_score;
    logic [INDEX_W-1:0]  top_index;
    logic [6:0]          match_q;
    logic signed [7:0]   miss_q;
    logic signed [7:0]   gap_q;

    cell_result_t        expected_cells [$];
    int                  fail_count;
    int                  cycle_count;
    int                  burst_left;
    logic                idle_on;
    logic [7:0]          row_q;

    smith_waterman_cell_scorer #(
        .SIDE_LENGTH(SIDE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .ref_position(ref_position),
        .ref_char(ref_char),
        .row_char(row_char),
        .start_req(start_req),
        .result_strobe(result_strobe),
        .cell_index(cell_index),
        .cell_score(cell_score),
        .direction(direction),
        .best_score(best_score),
        .best_index(best_index),
        .matrix_done(matrix_done),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic cell_result_t score_cell(logic [7:0] qch, logic restart);
        cell_result_t r;
        int idx;
        int row;
        int col;
        int best;
        int cand;
        int diag;
        logic [1:0] dir;
        if (restart || cell_pos >= CELLS)
            cell_pos = 0;
        idx = cell_pos;
        if (idx == 0)
        begin
            top_score = '0;
            top_index = '0;
        end
        row = idx / SIDE;
        col = idx % SIDE;
        best = 0;
        dir = DIR_CENTER;
        if (row != 0 && col != 0)
        begin
            diag = (col_chars[col] == qch) ? int'(match_q) : int'(miss_q);
            // strict compares: ties keep the earlier candidate
            cand = int'(diag_q) + diag;
            if (cand > best)
            begin
                best = cand;
                dir = DIR_NORTH_WEST;
            end
            cand = int'(row_above[col]) + int'(gap_q);
            if (cand > best)
            begin
                best = cand;
                dir = DIR_NORTH;
            end
            cand = int'(west_q) + int'(gap_q);
            if (cand > best)
            begin
                best = cand;
                dir = DIR_WEST;
            end
            if (best > int'(SCORE_MAX))
                best = int'(SCORE_MAX);
        end
        diag_q = row_above[col];
        row_above[col] = best[SCORE_W-1:0];
        west_q = best[SCORE_W-1:0];
        if (best[SCORE_W-1:0] > top_score)
        begin
            top_score = best[SCORE_W-1:0];
            top_index = idx[INDEX_W-1:0];
        end
        r.done = (idx == CELLS - 1);
        cell_pos = r.done ? 0 : idx + 1;
        r.index = idx[INDEX_W-1:0];
        r.score = best[SCORE_W-1:0];
        r.dir = dir;
        r.best = top_score;
        r.best_idx = top_index;
        return r;
    endfunction

    function automatic int next_col();
        if (cell_pos >= CELLS)
            return 0;
        return cell_pos % SIDE;
    endfunction

    // mostly a small alphabet so that matches are common
    function automatic logic [7:0] pick_char();
        logic [7:0] letters [4];
        letters = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        return letters[$urandom_range(0, 3)];
    endfunction

    function automatic logic [7:0] pick_penalty();
        case ($urandom_range(0, 9))
            0: return 8'h80;
            1: return 8'h00;
            2: return 8'($urandom_range(1, 127));
            default: return 8'(256 - $urandom_range(1, 128));
        endcase
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && result_strobe !== 1'b0)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("result with no cell waiting: index %0d", cell_index);
                fail_count++;
            end
            else
            begin
                want = expected_cells.pop_front();
                check_field("cell_index", want.index, cell_index);
                check_field("cell_score", want.score, cell_score);
                check_field("direction", want.dir, direction);
                check_field("best_score", want.best, best_score);
                check_field("best_index", want.best_idx, best_index);
                check_field("matrix_done", want.done, matrix_done);
            end
        end
    end

    task automatic send_item(logic f, logic [6:0] pos, logic [7:0] rch, logic [7:0] qch,
                             logic sreq);
        if (idle_on && burst_left == 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        else
            @(negedge clk);
        if (idle_on)
            burst_left--;
        start = 1'b1;
        func = f;
        ref_position = pos;
        ref_char = rch;
        row_char = qch;
        start_req = sreq;
        do @(posedge clk); while (busy !== 1'b0);
        if (f == FUNC_CELL)
            expected_cells.push_back(score_cell(qch, sreq));
        else if (int'(pos) < SIDE)
            col_chars[pos] = rch;
    endtask

    task automatic send_load(logic [6:0] pos, logic [7:0] ch);
        send_item(FUNC_LOAD, pos, ch, 8'($urandom), 1'($urandom));
    endtask

    // cells in raster order, one query character per row, with optional loads, restarts and noise
    task automatic run_cells(int count, logic restart_first, int load_pct, int restart_pm,
                             int noise_pct);
        int i;
        logic sreq;
        logic [6:0] pos;
        for (i = 0; i < count; i++)
        begin
            if (!(i == 0 && restart_first) && $urandom_range(0, 99) < load_pct)
            begin
                // often a column just ahead, so the new character is read soon
                pos = $urandom_range(0, 1) ? 7'($urandom)
                                           : 7'((next_col() + $urandom_range(0, 3)) % SIDE);
                send_load(pos, pick_char());
            end
            else
            begin
                sreq = (i == 0 && restart_first) || ($urandom_range(0, 999) < restart_pm);
                if (sreq || next_col() == 0)
                    row_q = pick_char();
                send_item(FUNC_CELL, 7'($urandom), 8'($urandom),
                          ($urandom_range(0, 99) < noise_pct) ? 8'($urandom) : row_q, sreq);
            end
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start = 1'b0;
        while (expected_cells.size() != 0) @(posedge clk);
        // loads leave no result, so give the pipeline time to empty
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_register(logic [1:0] idx, logic [7:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_MATCH:    match_q = data[6:0];
            CFG_MISMATCH: miss_q = data;
            CFG_GAP:      gap_q = data;
            default:      ;
        endcase
    endtask

    task automatic write_scores(logic [7:0] m, logic [7:0] mm, logic [7:0] g);
        wait_for_results();
        set_register(CFG_MATCH, m);
        set_register(CFG_MISMATCH, mm);
        set_register(CFG_GAP, g);
        set_register(CFG_UNUSED, 8'($urandom));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_reference_load();
        int c;
        for (c = 0; c < SIDE; c++)
            send_load(7'(c), (c == 0) ? 8'h00 : (c == SIDE - 1) ? 8'hFF : pick_char());
    endtask

    // default scores straight out of reset, no start request
    task automatic test_reset_scores();
        run_cells(SIDE + 10, 1'b0, 0, 0, 0);
    endtask

    // carries on through the matrix under extreme and out-of-range scores
    task automatic test_score_extremes();
        int k;
        logic [7:0] m_set  [5];
        logic [7:0] mm_set [5];
        logic [7:0] g_set  [5];
        m_set  = '{8'd127, 8'd0,  8'hFF, 8'd0,  8'd3};
        mm_set = '{8'h80,  8'h00, 8'h00, 8'h7F, 8'hFE};
        g_set  = '{8'h80,  8'h00, 8'h00, 8'h80, 8'h7F};
        for (k = 0; k < 5; k++)
        begin
            write_scores(m_set[k], mm_set[k], g_set[k]);
            run_cells(30, 1'b0, 0, 0, 0);
        end
    endtask

    task automatic test_restart_and_loads();
        write_scores(8'd2, 8'hFF, 8'hFF);
        run_cells(20, 1'b1, 0, 0, 0);
        run_cells(1, 1'b1, 0, 0, 0);
        run_cells(40, 1'b1, 20, 0, 0);
    endtask

    task automatic test_random_traffic();
        int ph;
        for (ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 3))
                0: write_scores({1'($urandom), 7'd0}, pick_penalty(), pick_penalty());
                1: write_scores({1'($urandom), 7'd127}, pick_penalty(), pick_penalty());
                default: write_scores(8'($urandom), pick_penalty(), pick_penalty());
            endcase
            idle_on = (ph != 2);
            burst_left = 0;
            run_cells(PHASE_ITEMS, 1'b0, 8, 3, 10);
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_LOAD;
        ref_position = '0;
        ref_char = '0;
        row_char = '0;
        start_req = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MATCH;
        cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;
        burst_left = 0;
        idle_on = 1'b1;
        row_q = '0;
        for (int c = 0; c < SIDE; c++)
        begin
            col_chars[c] = '0;
            row_above[c] = '0;
        end
        west_q = '0;
        diag_q = '0;
        cell_pos = 0;
        top_score = '0;
        top_index = '0;
        match_q = MATCH_RESET;
        miss_q = MISMATCH_RESET;
        gap_q = GAP_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reference_load();
        test_reset_scores();
        test_score_extremes();
        test_restart_and_loads();
        test_random_traffic();

        wait_for_results();
        if (fail_count == 0 && expected_cells.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/swcs_pkg.sv
src/swcs_ctrl.sv
src/swcs_datapath.sv
src/smith_waterman_cell_scorer.sv
tb/testbench.sv
